>>> sv/stta_pkg.sv
// Shared types, codes and constants for the sensor table with timeout aging.
`default_nettype none

package stta_pkg;

	// Default table depth and width of entry counts.
	localparam int TABLE_DEPTH_DEF = 32;
	localparam int CNT_W           = 8;

	// Register reset values.
	localparam logic [5:0]         ENTRY_COUNT_RST    = 6'd32;
	localparam logic [7:0]         TIMEOUT_LIMIT_RST  = 8'd10;
	localparam logic signed [15:0] INVALID_MARKER_RST = 16'sh7FFF;

	// Operation codes of a request.
	typedef enum logic [1:0] {
		MODE_PUT    = 2'd0,
		MODE_GET    = 2'd1,
		MODE_UPDATE = 2'd2,
		MODE_TICK   = 2'd3
	} mode_t;

	// Register indexes on the configuration port.
	typedef enum logic [1:0] {
		REG_ENTRY_COUNT    = 2'd0,
		REG_TIMEOUT_LIMIT  = 2'd1,
		REG_INVALID_MARKER = 2'd2
	} reg_idx_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_SINGLE
	} state_t;

	// One table entry.
	typedef struct packed {
		logic [63:0]        id;
		logic signed [15:0] temp;
		logic [7:0]         timeout;
	} entry_t;

	localparam entry_t ENTRY_RST = '{id: 64'd0, temp: INVALID_MARKER_RST, timeout: 8'd0};

	// One result.
	typedef struct packed {
		logic               status;
		logic [4:0]         hit_index;
		logic [63:0]        read_id;
		logic signed [15:0] read_temperature;
		logic [7:0]         read_timeout;
		logic               read_valid;
	} result_t;

endpackage

`default_nettype wire

>>> sv/stta_table.sv
// Entry memory with one write port, one registered read port and per-entry valid bits.
`default_nettype none

module stta_table
	import stta_pkg::*;
#(
	parameter int DEPTH = TABLE_DEPTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire entry_t        wr_entry,
	input  wire logic [AW-1:0] rd_addr,
	output entry_t             rd_entry
);

	entry_t     mem [DEPTH];
	logic       valid_q [DEPTH];
	entry_t     rd_data_q;
	logic       rd_valid_q;

	// Storage write and registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
		rd_data_q <= mem[rd_addr];
	end

	// An entry counts as written once any write reaches it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				valid_q[i] <= 1'b0;
			end
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	// Entries never written read as their reset contents.
	assign rd_entry = rd_valid_q ? rd_data_q : ENTRY_RST;

endmodule

`default_nettype wire

>>> sv/sensor_table_timeout_aging.sv
// Put and get load their result in the cycle after acceptance; update and tick walk the active
// entries one per cycle, loading the result when the walk ends (at most TABLE_DEPTH entries;
// an update stops at its first match). With no active entries, or for a put or get with an
// index beyond the table, the result loads at acceptance. A request is taken when idle and the
// result slot is free or emptying, so not while one is in progress. Reset restores the register
// defaults; the table reads back its reset contents at once through per-entry valid bits.
`default_nettype none

module sensor_table_timeout_aging
	import stta_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         mode,
	input  wire logic [4:0]         entry_index,
	input  wire logic [63:0]        dev_id,
	input  wire logic signed [15:0] temperature,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    status,
	output logic [4:0]              hit_index,
	output logic [63:0]             read_id,
	output logic signed [15:0]      read_temperature,
	output logic [7:0]              read_timeout,
	output logic                    read_valid
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	// Configuration registers.
	logic [5:0]         entry_count_q;
	logic [7:0]         timeout_limit_q;
	logic signed [15:0] invalid_marker_q;

	// Sequencer and request registers.
	state_t             state_q, state_d;
	mode_t              mode_q;
	logic [4:0]         idx_q;
	logic [63:0]        id_q;
	logic signed [15:0] temp_q;
	logic [CNT_W-1:0]   n_q;
	logic [AW-1:0]      dq_q;

	// Result slot.
	logic               out_valid_q;
	result_t            res_q;

	// Table port signals.
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	entry_t             wr_entry;
	logic [AW-1:0]      rd_addr;
	entry_t             rd_entry;

	logic               acc;
	logic               cfg_wr;
	mode_t              mode_in;
	logic               single_in;
	logic               in_range_in;
	logic [CNT_W-1:0]   n_in;
	logic               direct_in;
	logic               hit;
	logic               last;
	logic               res_load;
	result_t            res_d;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q    <= ENTRY_COUNT_RST;
			timeout_limit_q  <= TIMEOUT_LIMIT_RST;
			invalid_marker_q <= INVALID_MARKER_RST;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_ENTRY_COUNT:    entry_count_q    <= pwdata[5:0];
				REG_TIMEOUT_LIMIT:  timeout_limit_q  <= pwdata[7:0];
				REG_INVALID_MARKER: invalid_marker_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_ENTRY_COUNT:    prdata = {26'd0, entry_count_q};
			REG_TIMEOUT_LIMIT:  prdata = {24'd0, timeout_limit_q};
			REG_INVALID_MARKER: prdata = {16'd0, invalid_marker_q};
			default:            prdata = 32'd0;
		endcase
	end

	// Request decode at acceptance.
	assign in_ready    = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign acc         = in_valid && in_ready;
	assign mode_in     = mode_t'(mode);
	assign single_in   = (mode_in == MODE_PUT) || (mode_in == MODE_GET);
	assign in_range_in = CNT_W'(entry_index) < CNT_W'(TABLE_DEPTH);
	assign n_in        = (CNT_W'(entry_count_q) > CNT_W'(TABLE_DEPTH)) ?
		CNT_W'(TABLE_DEPTH) : CNT_W'(entry_count_q);
	assign direct_in   = single_in ? !in_range_in : (n_in == '0);

	// Walk status for the entry whose data is on the read port.
	assign hit  = (rd_entry.id == id_q);
	assign last = (CNT_W'(dq_q) == (n_q - CNT_W'(1)));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && !direct_in) begin
					state_d = single_in ? ST_SINGLE : ST_WALK;
				end
			end
			ST_WALK: begin
				if (last || ((mode_q == MODE_UPDATE) && hit)) begin
					state_d = ST_IDLE;
				end
			end
			ST_SINGLE: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Table access and result formation.
	always_comb begin
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = dq_q;
		wr_entry = rd_entry;
		res_load = 1'b0;
		res_d    = '0;
		case (state_q)
			ST_IDLE: begin
				rd_addr = single_in ? AW'(entry_index) : '0;
				if (acc && direct_in) begin
					res_load        = 1'b1;
					res_d.status    = (mode_in == MODE_GET) || (mode_in == MODE_UPDATE);
					res_d.hit_index = (mode_in == MODE_GET) ? entry_index : 5'd0;
				end
			end
			ST_WALK: begin
				rd_addr = last ? '0 : dq_q + AW'(1);
				if (mode_q == MODE_TICK) begin
					// Age the entry, or mark its temperature invalid at the limit.
					wr_en = 1'b1;
					if (rd_entry.timeout < timeout_limit_q) begin
						wr_entry.timeout = rd_entry.timeout + 8'd1;
					end else begin
						wr_entry.temp = invalid_marker_q;
					end
					res_load = last;
				end else if (hit) begin
					wr_en            = 1'b1;
					wr_entry.temp    = temp_q;
					wr_entry.timeout = 8'd0;
					res_load         = 1'b1;
					res_d.hit_index  = 5'(dq_q);
				end else if (last) begin
					res_load     = 1'b1;
					res_d.status = 1'b1;
				end
			end
			ST_SINGLE: begin
				wr_addr  = AW'(idx_q);
				res_load = 1'b1;
				if (mode_q == MODE_PUT) begin
					wr_en         = 1'b1;
					wr_entry.id   = id_q;
					wr_entry.temp = temp_q;
				end else begin
					res_d.hit_index        = idx_q;
					res_d.read_id          = rd_entry.id;
					res_d.read_temperature = rd_entry.temp;
					res_d.read_timeout     = rd_entry.timeout;
					res_d.read_valid       = $signed(rd_entry.temp) < $signed(invalid_marker_q);
				end
			end
			default: ;
		endcase
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dq_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_WALK) begin
				dq_q <= dq_q + AW'(1);
			end else begin
				dq_q <= '0;
			end
		end
	end

	// Request payload, captured when a request is taken.
	always_ff @(posedge clk) begin
		if (acc) begin
			mode_q <= mode_in;
			idx_q  <= entry_index;
			id_q   <= dev_id;
			temp_q <= temperature;
			n_q    <= n_in;
		end
	end

	// Result slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = res_q.status;
	assign hit_index        = res_q.hit_index;
	assign read_id          = res_q.read_id;
	assign read_temperature = res_q.read_temperature;
	assign read_timeout     = res_q.read_timeout;
	assign read_valid       = res_q.read_valid;

	// Entry storage.
	stta_table #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_entry (wr_entry),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry)
	);

endmodule

`default_nettype wire

>>> sim/tb_sensor_table_timeout_aging.sv
// Self-checking testbench for the sensor table with timeout aging.
`timescale 1ns / 1ps

module tb_sensor_table_timeout_aging;
	import stta_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_REPORTS  = 10;
	localparam int POOL_MAX     = 48;

	// One request as offered on the input channel.
	typedef struct {
		mode_t              mode;
		logic [4:0]         idx;
		logic [63:0]        id;
		logic signed [15:0] temp;
	} sensor_req_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [3:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         mode = '0;
	logic [4:0]         entry_index = '0;
	logic [63:0]        dev_id = '0;
	logic signed [15:0] temperature = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               status;
	logic [4:0]         hit_index;
	logic [63:0]        read_id;
	logic signed [15:0] read_temperature;
	logic [7:0]         read_timeout;
	logic               read_valid;

	// Shadow copy of the table and of the registers.
	logic [63:0]        id_tbl   [TABLE_DEPTH_DEF];
	logic signed [15:0] temp_tbl [TABLE_DEPTH_DEF];
	logic [7:0]         age_tbl  [TABLE_DEPTH_DEF];
	logic [5:0]         cfg_count;
	logic [7:0]         cfg_limit;
	logic signed [15:0] cfg_marker;

	sensor_req_t requests_due[$];
	result_t     replies_due[$];
	logic [63:0] id_pool[$];
	sensor_req_t cur_req;

	int  err_cnt = 0;
	int  n_sent = 0;
	int  n_settings = 0;
	int  n_found = 0;
	int  n_missed = 0;
	int  cyc = 0;
	int  send_gap = 0;
	int  recv_gap = 0;
	int  hold_left = 0;
	int  hold_reqs = 0;
	int  hold_done = 0;
	bit  calm = 1'b0;

	sensor_table_timeout_aging u_top (.*);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Apply one request to the shadow table and return the reply it should produce.
	function automatic result_t table_apply(sensor_req_t rq);
		result_t r;
		int      n;
		bit      found;
		r = '0;
		found = 1'b0;
		n = (cfg_count > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : cfg_count;
		case (rq.mode)
			MODE_PUT: begin
				id_tbl[rq.idx] = rq.id;
				temp_tbl[rq.idx] = rq.temp;
			end
			MODE_GET: begin
				r.hit_index = rq.idx;
				r.read_id = id_tbl[rq.idx];
				r.read_temperature = temp_tbl[rq.idx];
				r.read_timeout = age_tbl[rq.idx];
				r.read_valid = temp_tbl[rq.idx] < cfg_marker;
			end
			MODE_UPDATE: begin
				r.status = 1'b1;
				for (int i = 0; i < n; i++) begin
					if (!found && id_tbl[i] == rq.id) begin
						found = 1'b1;
						temp_tbl[i] = rq.temp;
						age_tbl[i] = '0;
						r.status = 1'b0;
						r.hit_index = i[4:0];
					end
				end
				if (found)
					n_found++;
				else
					n_missed++;
			end
			default: begin
				for (int i = 0; i < n; i++) begin
					if (age_tbl[i] < cfg_limit)
						age_tbl[i] = age_tbl[i] + 8'd1;
					else
						temp_tbl[i] = cfg_marker;
				end
			end
		endcase
		return r;
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// IDs are mostly drawn from those already put, so that updates find entries.
	function automatic logic [63:0] rand_id();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6 && id_pool.size() > 0)
			return id_pool[$urandom_range(0, id_pool.size() - 1)];
		else if (r < 8)
			return {$urandom, $urandom};
		else if (r == 8)
			return '0;
		return '1;
	endfunction

	// Temperatures lean toward the extremes and toward the current marker.
	function automatic logic signed [15:0] rand_temp();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return cfg_marker;
			3: return cfg_marker - 16'sd1;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic sensor_req_t rand_req();
		sensor_req_t rq;
		int          r;
		r = $urandom_range(0, 99);
		rq.idx = 5'($urandom_range(0, TABLE_DEPTH_DEF - 1));
		rq.id = rand_id();
		rq.temp = rand_temp();
		if (r < 30) begin
			rq.mode = MODE_PUT;
			id_pool.push_back(rq.id);
			if (id_pool.size() > POOL_MAX)
				id_pool.delete(0);
		end else if (r < 60) begin
			rq.mode = MODE_GET;
		end else if (r < 85) begin
			rq.mode = MODE_UPDATE;
		end else begin
			rq.mode = MODE_TICK;
		end
		return rq;
	endfunction

	function automatic sensor_req_t mk_req(mode_t m, logic [4:0] i, logic [63:0] id,
			logic signed [15:0] t);
		sensor_req_t rq;
		rq.mode = m;
		rq.idx = i;
		rq.id = id;
		rq.temp = t;
		return rq;
	endfunction

	// Register write: setup cycle, then access cycle until pready.
	task automatic write_reg(reg_idx_t r, logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (r)
			REG_ENTRY_COUNT:   cfg_count = v[5:0];
			REG_TIMEOUT_LIMIT: cfg_limit = v[7:0];
			default:           cfg_marker = v[15:0];
		endcase
	endtask

	task automatic set_config(logic [5:0] cnt, logic [7:0] lim, logic signed [15:0] mk);
		write_reg(REG_ENTRY_COUNT, {26'd0, cnt});
		write_reg(REG_TIMEOUT_LIMIT, {24'd0, lim});
		write_reg(REG_INVALID_MARKER, {16'd0, mk});
		n_settings++;
	endtask

	// Wait until every request has gone in and every reply has come back.
	task automatic wait_idle();
		do @(negedge clk);
		while (requests_due.size() != 0 || in_valid || replies_due.size() != 0);
	endtask

	task automatic run_phase(int n, bit quiet, bit press);
		@(negedge clk);
		calm = quiet;
		if (press)
			hold_reqs++;
		repeat (n) requests_due.push_back(rand_req());
		wait_idle();
		calm = 1'b0;
	endtask

	// Sender: offers queued requests, with random gaps between them.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				replies_due.push_back(table_apply(cur_req));
				n_sent++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0 && !calm) begin
					in_valid <= 1'b0;
					send_gap--;
				end else if (requests_due.size() > 0) begin
					cur_req = requests_due.pop_front();
					mode <= cur_req.mode;
					entry_index <= cur_req.idx;
					dev_id <= cur_req.id;
					temperature <= cur_req.temp;
					in_valid <= 1'b1;
					send_gap = gap_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic report(string what, result_t e, result_t a);
		err_cnt++;
		if (err_cnt <= MAX_REPORTS) begin
			$display("%0t mismatch (%s): expected st=%0d idx=%0d id=%h t=%0d to=%0d v=%0d",
				$realtime, what, e.status, e.hit_index, e.read_id, e.read_temperature,
				e.read_timeout, e.read_valid);
			$display("%0t                 got      st=%0d idx=%0d id=%h t=%0d to=%0d v=%0d",
				$realtime, a.status, a.hit_index, a.read_id, a.read_temperature,
				a.read_timeout, a.read_valid);
		end
	endtask

	// Receiver: checks each reply against the oldest one due, with random stalls.
	always @(posedge clk) begin
		result_t a;
		result_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				a.status = status;
				a.hit_index = hit_index;
				a.read_id = read_id;
				a.read_temperature = read_temperature;
				a.read_timeout = read_timeout;
				a.read_valid = read_valid;
				if (replies_due.size() == 0) begin
					report("reply with no request", '0, a);
				end else begin
					e = replies_due.pop_front();
					if (a.status !== e.status || a.hit_index !== e.hit_index ||
							a.read_id !== e.read_id ||
							a.read_temperature !== e.read_temperature ||
							a.read_timeout !== e.read_timeout ||
							a.read_valid !== e.read_valid)
						report("field", e, a);
				end
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
			end else if (calm) begin
				out_ready <= 1'b1;
			end else if (recv_gap > 0) begin
				out_ready <= 1'b0;
				recv_gap--;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					recv_gap = gap_len();
			end
		end
	end

	// Long hold-off of the receiver, started on demand and counted here.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_done != hold_reqs) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= hold_done + 1;
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cyc++;
		if (cyc > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d replies due", cyc, replies_due.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		logic [63:0] dup_id;
		dup_id = {$urandom, $urandom};
		cfg_count = ENTRY_COUNT_RST;
		cfg_limit = TIMEOUT_LIMIT_RST;
		cfg_marker = INVALID_MARKER_RST;
		for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
			id_tbl[i] = '0;
			temp_tbl[i] = INVALID_MARKER_RST;
			age_tbl[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests under the reset settings.
		@(negedge clk);
		requests_due.push_back(mk_req(MODE_GET, 5'd0, '0, '0));
		requests_due.push_back(mk_req(MODE_GET, 5'd31, '0, '0));
		requests_due.push_back(mk_req(MODE_UPDATE, 5'd0, '0, 16'sh0100));
		requests_due.push_back(mk_req(MODE_GET, 5'd0, '0, '0));
		requests_due.push_back(mk_req(MODE_TICK, 5'd0, '0, '0));
		requests_due.push_back(mk_req(MODE_GET, 5'd0, '0, '0));
		requests_due.push_back(mk_req(MODE_PUT, 5'd0, '1, 16'sh8000));
		requests_due.push_back(mk_req(MODE_PUT, 5'd31, 64'h0123_4567_89AB_CDEF, 16'sh7FFF));
		requests_due.push_back(mk_req(MODE_GET, 5'd0, '0, '0));
		requests_due.push_back(mk_req(MODE_GET, 5'd31, '0, '0));
		requests_due.push_back(mk_req(MODE_UPDATE, 5'd0, '1, 16'sh7FFE));
		requests_due.push_back(mk_req(MODE_GET, 5'd0, '0, '0));
		requests_due.push_back(mk_req(MODE_UPDATE, 5'd0, 64'hDEAD_BEEF_0000_0001, 16'sd5));
		requests_due.push_back(mk_req(MODE_UPDATE, 5'd0, 64'h0123_4567_89AB_CDEF, -16'sd1));
		requests_due.push_back(mk_req(MODE_PUT, 5'd7, dup_id, 16'sd5));
		requests_due.push_back(mk_req(MODE_PUT, 5'd3, dup_id, 16'sd6));
		requests_due.push_back(mk_req(MODE_UPDATE, 5'd0, dup_id, 16'sd7));
		requests_due.push_back(mk_req(MODE_GET, 5'd3, '0, '0));
		requests_due.push_back(mk_req(MODE_GET, 5'd7, '0, '0));
		requests_due.push_back(mk_req(MODE_TICK, 5'd0, '0, '0));
		requests_due.push_back(mk_req(MODE_GET, 5'd3, '0, '0));
		requests_due.push_back(mk_req(MODE_GET, 5'd31, '0, '0));
		id_pool.push_back('1);
		id_pool.push_back(64'h0123_4567_89AB_CDEF);
		id_pool.push_back(dup_id);
		wait_idle();
		run_phase(100, 1'b0, 1'b0);

		// One active entry, immediate timeout, nothing counts as valid.
		set_config(6'd1, 8'd0, 16'sh8000);
		run_phase(80, 1'b0, 1'b0);

		// No active entries: updates always miss and ticks change nothing.
		set_config(6'd0, 8'd255, 16'sd0);
		run_phase(50, 1'b0, 1'b0);

		// Count beyond the table, short limit, with the receiver backed up.
		set_config(6'd63, 8'd3, 16'sh7FFF);
		run_phase(100, 1'b1, 1'b1);

		// Random settings with no idling at all.
		set_config(6'($urandom_range(1, 32)), 8'($urandom_range(0, 255)), 16'($urandom));
		run_phase(100, 1'b1, 1'b0);

		// Full table with a moderate limit and marker.
		set_config(6'd32, 8'd10, 16'sd100);
		run_phase(120, 1'b0, 1'b0);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (replies_due.size() != 0) begin
			$display("%0d replies never arrived", replies_due.size());
			err_cnt += replies_due.size();
		end
		$display("Sent %0d requests under %0d register settings; %0d updates hit, %0d missed.",
			n_sent, n_settings + 1, n_found, n_missed);
		$display("Receiver held off once for %0d cycles; %0d mismatches seen.",
			HOLD_CYCLES, err_cnt);
		if (err_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
